>>> sv/bra_pkg.sv
`timescale 1ns / 1ps
package bra_pkg;

    // reset value of the maximum denominator register
    localparam int MAX_DEN_RESET = 4095;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_GCD,
        S_DIVP,
        S_DIVP_W,
        S_DIVQ,
        S_DIVQ_W,
        S_CHK2,
        S_L0,
        S_L1,
        S_L2,
        S_L3,
        S_L4,
        S_L5,
        S_L6,
        S_L7,
        S_L8,
        S_L9,
        S_L10,
        S_L11,
        S_L12,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_OUT
    } t_state;

    // multiplier operand pairs
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_P_BD,
        MUL_Q_AC,
        MUL_P_D,
        MUL_Q_C,
        MUL_P_B,
        MUL_Q_A,
        MUL_KX,
        MUL_KY,
        MUL_DC_B
    } t_mul_sel;

    // divider operand pairs
    typedef enum logic [1:0] {
        DIV_P_G,
        DIV_Q_G,
        DIV_KDEN,
        DIV_KR
    } t_div_sel;

    // result sources
    typedef enum logic [2:0] {
        RES_INVALID,
        RES_PASS,
        RES_MED,
        RES_UPPER,
        RES_LOWER
    } t_res_sel;

    typedef struct packed {
        logic     load_in;
        logic     gcd_init;
        logic     gcd_step;
        logic     g_load;
        logic     div_start;
        t_div_sel div_sel;
        logic     p_from_quot;
        logic     q_from_quot;
        logic     sb_init;
        t_mul_sel mul_sel;
        logic     t0_load;
        logic     t1_load;
        logic     t2_load;
        logic     gt_load;
        logic     dl_load;
        logic     kden_load;
        logic     kr_load;
        logic     k_load;
        logic     kx_load;
        logic     sb_update;
        logic     dc_load;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic q_zero;
        logic q_le_mx;
        logic gcd_done;
        logic div_done;
        logic bd_le_mx;
        logic lhs_eq;
        logic gt;
        logic qle;
        logic prod_le_t0;
        logic fin_upper;
        logic out_free;
    } t_sts;

endpackage

>>> sv/bra_if.sv
`timescale 1ns / 1ps
// input word: the fraction to approximate
interface bra_in_if #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] ratio_num;
    logic [VALUE_WIDTH-1:0] ratio_den;
    modport source(output valid, ratio_num, ratio_den, input ready);
    modport sink(input valid, ratio_num, ratio_den, output ready);
endinterface

// output word: the returned fraction
interface bra_out_if #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] result_num;
    logic [VALUE_WIDTH-1:0] result_den;
    logic                   invalid;
    modport source(output valid, result_num, result_den, invalid, input ready);
    modport sink(input valid, result_num, result_den, invalid, output ready);
endinterface

// configuration word: maximum denominator
interface bra_cfg_if #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

>>> sv/bra_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module bra_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_sh;
    logic [W:0]    w_diff;
    logic          w_ge;

    // trial subtract
    always_comb begin
        w_sh   = {r_rem, r_quo[W-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        w_diff = w_sh - {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

>>> sv/bra_ctrl.sv
`timescale 1ns / 1ps
module bra_ctrl
    import bra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // sequencing
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.q_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_INVALID;
                    n_state        = S_OUT;
                end else if (i_sts.q_le_mx) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_PASS;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.g_load = 1'b1;
                    n_state      = S_DIVP;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIVP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_P_G;
                n_state         = S_DIVP_W;
            end
            S_DIVP_W: begin
                if (i_sts.div_done) begin
                    o_cmd.p_from_quot = 1'b1;
                    n_state           = S_DIVQ;
                end
            end
            S_DIVQ: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_Q_G;
                n_state         = S_DIVQ_W;
            end
            S_DIVQ_W: begin
                if (i_sts.div_done) begin
                    o_cmd.q_from_quot = 1'b1;
                    n_state           = S_CHK2;
                end
            end
            S_CHK2: begin
                if (i_sts.q_le_mx) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_PASS;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.sb_init = 1'b1;
                    n_state       = S_L0;
                end
            end
            // mediant step: compare p/q with (a+c)/(b+d)
            S_L0: begin
                if (!i_sts.bd_le_mx) begin
                    n_state = S_F0;
                end else begin
                    o_cmd.mul_sel = MUL_P_BD;
                    n_state       = S_L1;
                end
            end
            S_L1: begin
                o_cmd.t0_load = 1'b1;
                o_cmd.mul_sel = MUL_Q_AC;
                n_state       = S_L2;
            end
            S_L2: begin
                if (i_sts.lhs_eq) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_MED;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.gt_load = 1'b1;
                    o_cmd.mul_sel = MUL_P_D;
                    n_state       = S_L3;
                end
            end
            S_L3: begin
                o_cmd.t0_load = 1'b1;
                o_cmd.mul_sel = MUL_Q_C;
                n_state       = S_L4;
            end
            S_L4: begin
                o_cmd.t1_load = 1'b1;
                o_cmd.mul_sel = MUL_P_B;
                n_state       = S_L5;
            end
            S_L5: begin
                o_cmd.t2_load = 1'b1;
                o_cmd.mul_sel = MUL_Q_A;
                n_state       = S_L6;
            end
            S_L6: begin
                o_cmd.dl_load   = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_KDEN;
                n_state         = S_L7;
            end
            // run length: limited by the denominator bound and by the target
            S_L7: begin
                if (i_sts.div_done) begin
                    o_cmd.kden_load = 1'b1;
                    if (i_sts.gt && i_sts.qle) begin
                        o_cmd.kr_load = 1'b1;
                        n_state       = S_L9;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_KR;
                        n_state         = S_L8;
                    end
                end
            end
            S_L8: begin
                if (i_sts.div_done) begin
                    o_cmd.kr_load = 1'b1;
                    n_state       = S_L9;
                end
            end
            S_L9: begin
                o_cmd.k_load = 1'b1;
                n_state      = S_L10;
            end
            S_L10: begin
                o_cmd.mul_sel = MUL_KX;
                n_state       = S_L11;
            end
            S_L11: begin
                o_cmd.kx_load = 1'b1;
                o_cmd.mul_sel = MUL_KY;
                n_state       = S_L12;
            end
            S_L12: begin
                o_cmd.sb_update = 1'b1;
                n_state         = S_L0;
            end
            // pick the closer bound
            S_F0: begin
                o_cmd.mul_sel = MUL_P_D;
                n_state       = S_F1;
            end
            S_F1: begin
                o_cmd.t0_load = 1'b1;
                o_cmd.mul_sel = MUL_Q_C;
                n_state       = S_F2;
            end
            S_F2: begin
                if (i_sts.prod_le_t0) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_UPPER;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.dc_load = 1'b1;
                    n_state       = S_F3;
                end
            end
            S_F3: begin
                o_cmd.mul_sel = MUL_DC_B;
                n_state       = S_F4;
            end
            S_F4: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = i_sts.fin_upper ? RES_UPPER : RES_LOWER;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register loaded while full");

endmodule

>>> sv/bra_dp.sv
`timescale 1ns / 1ps
module bra_dp
    import bra_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  logic [W-1:0] i_ratio_num,
    input  logic [W-1:0] i_ratio_den,
    input  logic         i_cfg_valid,
    input  logic [W-1:0] i_cfg_data,
    output logic         o_cfg_ready,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [W-1:0] o_result_num,
    output logic [W-1:0] o_result_den,
    output logic         o_invalid
);
    localparam int SW = $clog2(W + 1);

    logic [W-1:0]   r_cfg;
    logic [W-1:0]   r_p, r_q, r_mx;
    logic [W-1:0]   r_u, r_v, r_g;
    logic [SW-1:0]  r_sh;
    logic [W-1:0]   r_a, r_b, r_c, r_d;
    logic [2*W-1:0] r_prod, r_t0, r_t1, r_t2;
    logic           r_gt, r_qle;
    logic [W-1:0]   r_dl, r_e;
    logic [W-1:0]   r_kden, r_kr, r_k, r_kx;
    logic [W-1:0]   r_rn, r_rd;
    logic           r_ri;
    logic           r_out_valid;
    logic [W-1:0]   r_on, r_od;
    logic           r_oi;

    logic [W:0]     w_bd;
    logic [W-1:0]   w_ac;
    logic [W-1:0]   w_ma, w_mb;
    logic [W-1:0]   w_dnum, w_dden;
    logic           w_div_done;
    logic [W-1:0]   w_quot;

    assign w_bd = {1'b0, r_b} + {1'b0, r_d};
    assign w_ac = r_a + r_c;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= W'(MAX_DEN_RESET);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_NONE: begin w_ma = '0;   w_mb = '0;           end
            MUL_P_BD: begin w_ma = r_p;  w_mb = w_bd[W-1:0];  end
            MUL_Q_AC: begin w_ma = r_q;  w_mb = w_ac;         end
            MUL_P_D:  begin w_ma = r_p;  w_mb = r_d;          end
            MUL_Q_C:  begin w_ma = r_q;  w_mb = r_c;          end
            MUL_P_B:  begin w_ma = r_p;  w_mb = r_b;          end
            MUL_Q_A:  begin w_ma = r_q;  w_mb = r_a;          end
            MUL_KX:   begin w_ma = r_k;  w_mb = r_gt ? r_c : r_a; end
            MUL_KY:   begin w_ma = r_k;  w_mb = r_gt ? r_d : r_b; end
            MUL_DC_B: begin w_ma = r_dl; w_mb = r_b;          end
            default:  begin w_ma = '0;   w_mb = '0;           end
        endcase
    end

    // shared divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_P_G: begin w_dnum = r_p; w_dden = r_g; end
            DIV_Q_G: begin w_dnum = r_q; w_dden = r_g; end
            DIV_KDEN: begin
                w_dnum = r_gt ? (r_mx - r_b) : (r_mx - r_d);
                w_dden = r_gt ? r_d : r_b;
            end
            DIV_KR: begin
                w_dnum = r_gt ? (r_dl - W'(1)) : (r_e - W'(1));
                w_dden = r_gt ? r_e : r_dl;
            end
            default: begin w_dnum = r_p; w_dden = r_g; end
        endcase
    end

    bra_div #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= {{W{1'b0}}, w_ma} * {{W{1'b0}}, w_mb};
        if (i_cmd.load_in) begin
            r_p  <= i_ratio_num;
            r_q  <= i_ratio_den;
            r_mx <= (r_cfg == '0) ? W'(1) : r_cfg;
        end
        if (i_cmd.p_from_quot) r_p <= w_quot;
        if (i_cmd.q_from_quot) r_q <= w_quot;

        // binary gcd, one step per cycle
        if (i_cmd.gcd_init) begin
            r_u  <= r_p;
            r_v  <= r_q;
            r_sh <= '0;
        end else if (i_cmd.gcd_step) begin
            priority if (!r_u[0] && !r_v[0]) begin
                r_u  <= r_u >> 1;
                r_v  <= r_v >> 1;
                r_sh <= r_sh + SW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= r_v;
                r_v <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        if (i_cmd.g_load) r_g <= (r_u == '0) ? r_v : (r_u << r_sh);

        // bounds
        if (i_cmd.sb_init) begin
            r_a <= '0;
            r_b <= W'(1);
            r_c <= W'(1);
            r_d <= W'(1);
        end else if (i_cmd.sb_update) begin
            if (r_gt) begin
                r_a <= r_a + r_kx;
                r_b <= r_b + r_prod[W-1:0];
            end else begin
                r_c <= r_c + r_kx;
                r_d <= r_d + r_prod[W-1:0];
            end
        end

        if (i_cmd.t0_load) r_t0 <= r_prod;
        if (i_cmd.t1_load) r_t1 <= r_prod;
        if (i_cmd.t2_load) r_t2 <= r_prod;
        if (i_cmd.gt_load) r_gt <= r_t0 > r_prod;
        // distances to the target: p*b - q*a and q*c - p*d
        if (i_cmd.dl_load) begin
            r_dl  <= W'(r_t2 - r_prod);
            r_e   <= W'(r_t1 - r_t0);
            r_qle <= r_t1 <= r_t0;
        end else if (i_cmd.dc_load) begin
            r_dl <= W'(r_prod - r_t0);
        end
        if (i_cmd.kden_load) r_kden <= w_quot;
        if (i_cmd.kr_load)   r_kr   <= w_quot;
        if (i_cmd.k_load)    r_k    <= (r_kr < r_kden) ? r_kr : r_kden;
        if (i_cmd.kx_load)   r_kx   <= r_prod[W-1:0];

        // result select
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_INVALID: begin r_rn <= '0;   r_rd <= W'(1);      r_ri <= 1'b1; end
                RES_PASS:    begin r_rn <= r_p;  r_rd <= r_q;        r_ri <= 1'b0; end
                RES_MED:     begin r_rn <= w_ac; r_rd <= w_bd[W-1:0]; r_ri <= 1'b0; end
                RES_UPPER:   begin r_rn <= r_c;  r_rd <= r_d;        r_ri <= 1'b0; end
                RES_LOWER:   begin r_rn <= r_a;  r_rd <= r_b;        r_ri <= 1'b0; end
                default:     begin r_rn <= r_a;  r_rd <= r_b;        r_ri <= 1'b0; end
            endcase
        end

        if (i_cmd.out_load) begin
            r_on <= r_rn;
            r_od <= r_rd;
            r_oi <= r_ri;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_result_num = r_on;
    assign o_result_den = r_od;
    assign o_invalid    = r_oi;

    // status to controller
    always_comb begin
        o_sts.q_zero     = (r_q == '0);
        o_sts.q_le_mx    = (r_q <= r_mx);
        o_sts.gcd_done   = (r_u == '0) || (r_v == '0);
        o_sts.div_done   = w_div_done;
        o_sts.bd_le_mx   = (w_bd <= {1'b0, r_mx});
        o_sts.lhs_eq     = (r_t0 == r_prod);
        o_sts.gt         = r_gt;
        o_sts.qle        = r_qle;
        o_sts.prod_le_t0 = (r_prod <= r_t0);
        o_sts.fin_upper  = ({r_prod, 1'b0} < {{(W + 1){1'b0}}, r_q});
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    a_step_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sb_update |-> (r_k != '0))
        else $error("bound update with zero run length");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_od != '0))
        else $error("zero result denominator");

endmodule

>>> sv/best_rational_approximation.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                 Handshake
// i_in     in   ratio_num, ratio_den                    valid/ready
// o_out    out  result_num, result_den, invalid         valid/ready
// i_cfg    in   data (max_denominator)                  valid/ready, ready always high
//
// One word at a time. Pass-through and zero denominators go straight to the output.
// Otherwise a binary GCD and two divisions by the GCD follow, then the mediant
// search, whose runs are set by the shared bit-serial divider.
// Reset is synchronous, active low; max_denominator returns to 4095.
// A new word is taken while a finished result waits in the output register.
module best_rational_approximation
    import bra_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bra_in_if.sink    i_in,
    bra_out_if.source o_out,
    bra_cfg_if.sink   i_cfg
);
    t_cmd w_cmd;
    t_sts w_sts;

    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bra_dp #(.W(VALUE_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_ratio_num  (i_in.ratio_num),
        .i_ratio_den  (i_in.ratio_den),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (i_cfg.ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_result_num (o_out.result_num),
        .o_result_den (o_out.result_den),
        .o_invalid    (o_out.invalid)
    );

endmodule
